/* rtl/core/cwmd_pkg.sv */
// ----------------------------------------------------------------------------
// cwmd_pkg: shared types and constants for the centered window minimum drop
// Sample and result item layouts, chain dimensions and chain control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package cwmd_pkg;

    localparam int MAX_HALF_WIDTH = 31;
    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_BITS       = 5;
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
    localparam int HW_BITS        = $clog2(MAX_HALF_WIDTH + 1);
    localparam int IDX_BITS       = $clog2(WIN_DEPTH);
    localparam int CNT_BITS       = $clog2(WIN_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] HALF_WIDTH_RESET = CFG_BITS'(1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = '1;

    typedef struct packed {
        sample_t sample;
        logic    end_of_sequence;
    } in_item_t;

    typedef struct packed {
        sample_t drop;
        logic    final_result;
    } out_item_t;

    // What the controller tells the cell row in one cycle
    typedef struct packed {
        logic    shift;
        logic    first;
        sample_t sample;
    } chain_ctl_t;

endpackage : cwmd_pkg

`default_nettype wire

/* rtl/core/cwmd_cell.sv */
// ----------------------------------------------------------------------------
// cwmd_cell: one stage of the sample and running minimum chain
// Holds one sample and the minimum of it and every newer sample.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmd_cell
    import cwmd_pkg::*;
(
    input  wire logic       aclk,
    input  wire chain_ctl_t ctl,
    input  wire sample_t    ws_prev,
    input  wire sample_t    rm_prev,
    output      sample_t    ws,
    output      sample_t    rm
);

    sample_t ws_reg;
    sample_t rm_reg;
    sample_t rm_next;

    // A new sequence restarts the minimum, so older entries never leak in
    always_comb begin
        if (ctl.first) begin
            rm_next = ctl.sample;
        end else if (rm_prev < ctl.sample) begin
            rm_next = rm_prev;
        end else begin
            rm_next = ctl.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            ws_reg <= ws_prev;
            rm_reg <= rm_next;
        end
    end

    assign ws = ws_reg;
    assign rm = rm_reg;

endmodule : cwmd_cell

`default_nettype wire

/* rtl/core/cwmd_chain.sv */
// ----------------------------------------------------------------------------
// cwmd_chain: row of minimum cells with the centre and window taps
// Entry 0 is the newest sample; the centre sits at k, the window end at 2k.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmd_chain
    import cwmd_pkg::*;
(
    input  wire logic               aclk,
    input  wire chain_ctl_t         ctl,
    input  wire logic [HW_BITS-1:0] k,
    output      sample_t            drop
);

    sample_t ws [WIN_DEPTH];
    sample_t rm [WIN_DEPTH];
    sample_t ws_tap;
    sample_t rm_tap;

    for (genvar p = 0; p < WIN_DEPTH; p++) begin : g_cell
        if (p == 0) begin : g_head
            cwmd_cell u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .ws_prev (ctl.sample),
                .rm_prev (SAMPLE_MAX),
                .ws      (ws[p]),
                .rm      (rm[p])
            );
        end else begin : g_body
            cwmd_cell u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .ws_prev (ws[p-1]),
                .rm_prev (rm[p-1]),
                .ws      (ws[p]),
                .rm      (rm[p])
            );
        end
    end

    assign ws_tap = ws[IDX_BITS'(k)];
    assign rm_tap = rm[IDX_BITS'({k, 1'b0})];
    assign drop   = ws_tap - rm_tap;

endmodule : cwmd_chain

`default_nettype wire

/* rtl/core/centered_window_min_drop.sv */
// ----------------------------------------------------------------------------
// centered_window_min_drop: centre sample minus its clipped window minimum
// Input channel s_* carries samples with an end-of-sequence flag; output
// channel m_* carries one drop per sample, the last one flagged final.
// With half width k, result i leaves once sample i+k is in. Items enter at
// one per clock while s_ready is high; once sample i+k is accepted, result i
// passes pend_reg and then the output register on its way to m_valid.
// On an end-of-sequence item the block takes no new sample while it pushes k
// filler entries through the cell row and drains the results still owed (at
// most k), one per clock while the receiver keeps m_ready high.
// The cell row (63 cells) bounds the window; taps sit at cell k and 2k.
// When the receiver stalls, the output register holds its item and one
// more result waits in the row; s_ready drops when both are full and while
// a sequence tail drains. cfg_wr_en writes the half width (reset 1) at once;
// write it only while no item is under way. Reset clears the control state and
// the sequence count; the row contents are never read before they are refilled.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_window_min_drop
    import cwmd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_BITS-1:0] cfg_wr_data,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire in_item_t            s_data,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      out_item_t           m_data
);

    logic [CFG_BITS-1:0] half_width_reg;
    logic [HW_BITS-1:0]  k;

    logic [CNT_BITS-1:0] seen_reg,  seen_next;
    logic                flush_reg, flush_next;
    logic [HW_BITS-1:0]  ghost_reg, ghost_next;
    logic [HW_BITS-1:0]  lo_reg,    lo_next;
    logic                pend_reg,  pend_next;
    logic                final_reg, final_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg;

    logic               out_free;
    logic               move;
    logic               chain_free;
    logic               accept;
    logic               step;
    logic               seen_ge_k;
    logic [HW_BITS-1:0] ghost_inc;
    chain_ctl_t         ctl;
    sample_t            drop;

    assign k = (half_width_reg > CFG_BITS'(MAX_HALF_WIDTH)) ?
               HW_BITS'(MAX_HALF_WIDTH) : HW_BITS'(half_width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HALF_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            half_width_reg <= cfg_wr_data;
        end
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign move       = pend_reg && out_free;
    assign chain_free = !pend_reg || move;
    assign s_ready    = chain_free && !flush_reg;
    assign accept     = s_valid && s_ready;
    assign step       = chain_free && flush_reg;
    assign seen_ge_k  = seen_reg >= CNT_BITS'(k);
    assign ghost_inc  = ghost_reg + HW_BITS'(1);

    // Filler entries are all ones so they never win a minimum
    always_comb begin
        ctl.shift  = accept || step;
        ctl.first  = accept && (seen_reg == '0);
        ctl.sample = accept ? s_data.sample : SAMPLE_MAX;
    end

    always_comb begin
        seen_next  = seen_reg;
        flush_next = flush_reg;
        ghost_next = ghost_reg;
        lo_next    = lo_reg;
        pend_next  = pend_reg;
        final_next = final_reg;
        if (move) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            pend_next  = seen_ge_k;
            final_next = s_data.end_of_sequence && (k == '0);
            if (s_data.end_of_sequence) begin
                // Oldest owed centre sits below cell k when the sequence is short
                seen_next  = '0;
                flush_next = (k != '0);
                ghost_next = '0;
                lo_next    = seen_ge_k ? '0 : (k - HW_BITS'(seen_reg));
            end else if (seen_reg != CNT_BITS'(WIN_DEPTH)) begin
                seen_next = seen_reg + CNT_BITS'(1);
            end
        end else if (step) begin
            // Each filler push moves the next owed centre onto cell k
            ghost_next = ghost_inc;
            pend_next  = ghost_inc >= lo_reg;
            final_next = ghost_inc == k;
            flush_next = ghost_inc != k;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            flush_reg   <= 1'b0;
            ghost_reg   <= '0;
            lo_reg      <= '0;
            pend_reg    <= 1'b0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            flush_reg   <= flush_next;
            ghost_reg   <= ghost_next;
            lo_reg      <= lo_next;
            pend_reg    <= pend_next;
            final_reg   <= final_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_data_reg.drop         <= drop;
            m_data_reg.final_result <= final_reg;
        end
    end

    cwmd_chain u_chain (
        .aclk (aclk),
        .ctl  (ctl),
        .k    (k),
        .drop (drop)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : centered_window_min_drop

`default_nettype wire

/* rtl/core/cwmd_checker.sv */
// ----------------------------------------------------------------------------
// cwmd_checker: port-level checks for the centered window minimum drop
// Watches reset, output hold under stall and the flush gap after a last item.
// ----------------------------------------------------------------------------
`default_nettype none

module cwmd_checker
    import cwmd_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                cfg_wr_en,
    input wire logic [CFG_BITS-1:0] cfg_wr_data,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire in_item_t            s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire out_item_t           m_data
);

    logic [CFG_BITS-1:0] hw_reg;

    // Track the half width as written through the port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= HALF_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            hw_reg <= cfg_wr_data;
        end
    end

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_flush_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.end_of_sequence && (hw_reg != '0)
        |=> !s_ready)
        else $error("sample taken while the sequence tail drains");

endmodule : cwmd_checker

bind centered_window_min_drop cwmd_checker u_cwmd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

`default_nettype wire
